[hdl/lrsr_pkg.sv]
package lrsr_pkg;

  // default screen size
  localparam int DEF_DISP_COLS = 128;
  localparam int DEF_DISP_ROWS = 64;

  // stream widths
  localparam int IN_W   = 128;
  localparam int COORD_W = 32;

  // centered 16.16 coordinate, one bit wider than the input
  localparam int AW = 33;
  // slope divisor, numerator magnitude and signed slope
  localparam int DW = 27;
  localparam int NW = 42;
  localparam int KW = NW + 1;
  // multiplier operand (row count or sub-pixel fraction)
  localparam int MW = 16;
  // shift applied to the product on the sub-pixel path
  localparam int SUB_SHIFT = 4;
  // running x accumulator and its integer column part
  localparam int XW  = KW + 1 + MW - SUB_SHIFT;
  localparam int PXW = XW - 16;
  // shared iteration counter
  localparam int CNT_W = 6;

  localparam int ONE_PIXEL   = 65536;
  localparam int FRAC_SHIFT  = 12;
  localparam int SLOPE_SHIFT = 10;
  localparam int DEN_SHIFT   = 6;

  localparam logic signed [AW-1:0] HALF_PIXEL = 33'sd32768;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_FIX   = 7'b0010000,
    ST_ROW   = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

  // sign-extend one input coordinate and move it by half a pixel
  function automatic logic signed [AW-1:0] centre(input logic [COORD_W-1:0] v);
    logic signed [AW-1:0] s;
    s = $signed({v[COORD_W-1], v});
    return s + HALF_PIXEL;
  endfunction

endpackage

[hdl/line_row_span_rasterizer.sv]
// channel | dir | ports               | word layout (low bit first)
// in_     | in  | tvalid/tready/tdata | start_x[31:0] start_y[63:32] end_x[95:64] end_y[127:96]
// out_    | out | tvalid/tready/tdata | row, first_col, last_col, zero pad; tlast = final_span
//
// a line passes through setup, the divider for the slope (skipped when the divisor
// is zero), the multiplier for the top clip or sub-pixel step, a fix-up state, the
// row walk and a flush state before the next word is taken; a culled line goes
// from setup straight back to idle.
// rst_n is synchronous and active low; it clears the sequencer and the valid flags.
// a new line is taken only in idle; a stalled output freezes the row walk.
module line_row_span_rasterizer
  import lrsr_pkg::*;
#(
  parameter int DISP_COLS = DEF_DISP_COLS,
  parameter int DISP_ROWS = DEF_DISP_ROWS,
  localparam int CW = $clog2(DISP_COLS),
  localparam int RW = $clog2(DISP_ROWS),
  localparam int OW = ((RW + 2 * CW + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OW-1:0]   out_tdata,  // row, first_col, last_col, zero pad
  output logic            out_tlast   // final_span
);

  localparam logic signed [AW-1:0] W_FIX = AW'(DISP_COLS * ONE_PIXEL);
  localparam logic signed [AW-1:0] H_FIX = AW'(DISP_ROWS * ONE_PIXEL);
  localparam logic signed [PXW:0]  COL_MAX = (PXW + 1)'(DISP_COLS - 1);
  localparam logic [RW-1:0]        ROW_MAX = RW'(DISP_ROWS - 1);

  state_t state_r, state_nxt;

  // endpoint registers
  logic signed [AW-1:0] ax_r, ay_r, bx_r, by_r;

  // divider
  logic [DW-1:0]         den_r;
  logic [DW-1:0]         rem_r;
  logic [NW-1:0]         qn_r;
  logic                  neg_r;
  logic [CNT_W-1:0]      cnt_r;
  logic signed [KW-1:0]  kx_r;

  // multiplier
  logic signed [KW:0]    acc_hi_r;
  logic [MW-1:0]         acc_lo_r;
  logic [MW-1:0]         mq_r;
  logic                  y0neg_r;

  // row walk
  logic signed [XW-1:0]  x_r;
  logic signed [PXW-1:0] prev_r;
  logic                  first_r;
  logic [RW-1:0]         py_r, py1_r;

  // pending span, held until we know whether it is the last one
  logic                  pend_v_r;
  logic [RW-1:0]         pend_row_r;
  logic [CW-1:0]         pend_lo_r, pend_hi_r;

  // output register
  logic                  out_valid_r;
  logic [RW-1:0]         out_row_r;
  logic [CW-1:0]         out_first_r, out_last_r;
  logic                  out_final_r;

  // setup: order endpoints, cull, divisor, numerator, multiplier operand and row bounds
  logic                  a_first;
  logic signed [AW-1:0]  sx0, sy0, sx1, sy1;
  logic                  cull;
  logic signed [AW:0]    dy, dx, dx_mag;
  logic [DW-1:0]         den;
  logic [NW-1:0]         num;
  logic [AW-17:0]        yint, neg_yint;
  logic [MW-1:0]         mq_init;
  logic [RW-1:0]         py0, py1;

  always_comb begin
    a_first  = ay_r < by_r;
    sx0      = a_first ? ax_r : bx_r;
    sy0      = a_first ? ay_r : by_r;
    sx1      = a_first ? bx_r : ax_r;
    sy1      = a_first ? by_r : ay_r;
    cull     = (ax_r[AW-1] && bx_r[AW-1]) || (ax_r >= W_FIX && bx_r >= W_FIX) ||
               sy1[AW-1] || (sy0 >= H_FIX);
    dy       = {sy1[AW-1], sy1} - {sy0[AW-1], sy0};
    den      = dy[DW+DEN_SHIFT-1:DEN_SHIFT];
    dx       = {sx1[AW-1], sx1} - {sx0[AW-1], sx0};
    dx_mag   = dx[AW] ? -dx : dx;
    num      = {dx_mag[NW-SLOPE_SHIFT-1:0], SLOPE_SHIFT'(0)};
    yint     = sy0[AW-1:16];
    neg_yint = -yint;
    mq_init  = sy0[AW-1] ? neg_yint[MW-1:0] : MW'(sy0[15:FRAC_SHIFT]);
    py0      = sy0[AW-1] ? '0 : sy0[16+RW-1:16];
    py1      = (sy1 >= H_FIX) ? ROW_MAX : sy1[16+RW-1:16];
  end

  // divider: one quotient bit per cycle, restoring
  logic [DW:0]          cand, diff;
  logic                 ge;
  logic [DW-1:0]        rem_nxt;
  logic [NW-1:0]        qn_nxt;
  logic signed [KW-1:0] q_pos, kx_div;

  always_comb begin
    cand    = {rem_r, qn_r[NW-1]};
    diff    = cand - {1'b0, den_r};
    ge      = cand >= {1'b0, den_r};
    rem_nxt = ge ? diff[DW-1:0] : cand[DW-1:0];
    qn_nxt  = {qn_r[NW-2:0], ge};
    q_pos   = $signed({1'b0, qn_nxt});
    kx_div  = neg_r ? -q_pos : q_pos;
  end

  // multiplier: one operand bit per cycle, product shifts right
  logic signed [KW:0]        addend, sum;
  logic signed [KW+MW:0]     prod;
  logic signed [XW-1:0]      x_fix;

  always_comb begin
    addend = mq_r[0] ? {kx_r[KW-1], kx_r} : '0;
    sum    = acc_hi_r + addend;
    prod   = {acc_hi_r, acc_lo_r};
    x_fix  = y0neg_r ? x_r + {{(XW-KW-1){acc_hi_r[KW]}}, acc_hi_r}
                     : x_r - prod[KW+MW:SUB_SHIFT];
  end

  // row walk: column of this row and the span joining it to the last one
  logic signed [PXW-1:0] px;
  logic signed [PXW:0]   pxe, pve, lo, hi, lo_c, hi_c;
  logic                  emit;
  logic                  out_free;

  always_comb begin
    px   = x_r[XW-1:16];
    pxe  = {px[PXW-1], px};
    pve  = {prev_r[PXW-1], prev_r};
    if (first_r || pxe == pve) begin
      lo = pxe;
      hi = pxe;
    end else if (pve < pxe) begin
      lo = pve + (PXW + 1)'(1);
      hi = pxe;
    end else begin
      lo = pxe;
      hi = pve - (PXW + 1)'(1);
    end
    lo_c     = lo[PXW] ? '0 : lo;
    hi_c     = (hi > COL_MAX) ? COL_MAX : hi;
    emit     = lo_c <= hi_c;
    out_free = !out_valid_r || out_tready;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (cull)           state_nxt = ST_IDLE;
        else if (den == '0) state_nxt = ST_MUL;
        else                state_nxt = ST_DIV;
      end
      ST_DIV:   if (cnt_r == CNT_W'(NW - 1)) state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == CNT_W'(MW - 1)) state_nxt = ST_FIX;
      ST_FIX:   state_nxt = ST_ROW;
      ST_ROW:   if (out_free && py_r == py1_r) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!pend_v_r || out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // output register load: a pending span moves out
  logic load_out;

  always_comb begin
    case (state_r)
      ST_ROW:   load_out = out_free && emit && pend_v_r;
      ST_FLUSH: load_out = out_free && pend_v_r;
      default:  load_out = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_ROW: begin
          if (out_free && emit) pend_v_r <= 1'b1;
        end
        ST_FLUSH: begin
          if (pend_v_r && out_free) pend_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ax_r <= centre(in_tdata[31:0]);
          ay_r <= centre(in_tdata[63:32]);
          bx_r <= centre(in_tdata[95:64]);
          by_r <= centre(in_tdata[127:96]);
        end
      end
      ST_SETUP: begin
        den_r    <= den;
        rem_r    <= '0;
        qn_r     <= num;
        neg_r    <= dx[AW];
        cnt_r    <= '0;
        kx_r     <= '0;
        x_r      <= {{(XW-AW){sx0[AW-1]}}, sx0};
        y0neg_r  <= sy0[AW-1];
        mq_r     <= mq_init;
        acc_hi_r <= '0;
        acc_lo_r <= '0;
        py_r     <= py0;
        py1_r    <= py1;
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        qn_r  <= qn_nxt;
        if (cnt_r == CNT_W'(NW - 1)) begin
          kx_r  <= kx_div;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        acc_hi_r <= {sum[KW], sum[KW:1]};
        acc_lo_r <= {sum[0], acc_lo_r[MW-1:1]};
        mq_r     <= {1'b0, mq_r[MW-1:1]};
        cnt_r    <= cnt_r + 1'b1;
      end
      ST_FIX: begin
        x_r     <= x_fix;
        first_r <= 1'b1;
      end
      ST_ROW: begin
        if (out_free) begin
          if (emit) begin
            pend_row_r <= py_r;
            pend_lo_r  <= lo_c[CW-1:0];
            pend_hi_r  <= hi_c[CW-1:0];
            if (pend_v_r) begin
              out_row_r   <= pend_row_r;
              out_first_r <= pend_lo_r;
              out_last_r  <= pend_hi_r;
              out_final_r <= 1'b0;
            end
          end
          first_r <= 1'b0;
          prev_r  <= px;
          x_r     <= x_r + {{(XW-KW){kx_r[KW-1]}}, kx_r};
          if (py_r != py1_r) py_r <= py_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_row_r   <= pend_row_r;
          out_first_r <= pend_lo_r;
          out_last_r  <= pend_hi_r;
          out_final_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_last_r, out_first_r, out_row_r});
  assign out_tlast  = out_final_r;

  // checks on the row walk and span output
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_first_r <= out_last_r) && (out_last_r <= CW'(DISP_COLS - 1)))
    else $error("span columns out of order or off screen");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> (py_r <= py1_r))
    else $error("row counter passed the last row");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_v_r)
    else $error("pending span left over while idle");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && !pend_v_r) |=> (state_r == ST_IDLE))
    else $error("flush did not return to idle");

endmodule
